>>> hw/rtl/logic_analyzer_trigger_capture_defines.svh
// assertion macros for the logic analyzer trigger and capture block
`ifndef LOGIC_ANALYZER_TRIGGER_CAPTURE_DEFINES_SVH
`define LOGIC_ANALYZER_TRIGGER_CAPTURE_DEFINES_SVH
`ifndef ASSERT_OFF
// clocked check, suspended while reset is asserted
`define LATC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
// clocked check that also holds across reset
`define LATC_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define LATC_ASSERT(lbl, prop, msg)
`define LATC_ASSERT_RST(lbl, prop, msg)
`endif
`endif

>>> hw/rtl/latc_pkg.sv
// shared types and codes of the logic analyzer trigger and capture block
package latc_pkg;

    // request function codes
    typedef enum logic [1:0] {
        FUNC_START  = 2'd0,
        FUNC_SAMPLE = 2'd1,
        FUNC_STOP   = 2'd2
    } func_t;

    // result kinds
    typedef enum logic [2:0] {
        KIND_STARTED  = 3'd0,
        KIND_FIRED    = 3'd1,
        KIND_RECORD   = 3'd2,
        KIND_PRE_REC  = 3'd3,
        KIND_FLUSH    = 3'd4,
        KIND_STOPPED  = 3'd5
    } kind_t;

    // stop reasons
    typedef enum logic [1:0] {
        STOP_POST_DONE = 2'd0,
        STOP_OVERFLOW  = 2'd1,
        STOP_HOST      = 2'd2
    } stop_t;

    // configuration register indexes
    localparam logic [2:0] CFG_TRIGGER_MODE  = 3'd0;
    localparam logic [2:0] CFG_PATTERN_MASK  = 3'd1;
    localparam logic [2:0] CFG_PATTERN_VALUE = 3'd2;
    localparam logic [2:0] CFG_EDGE_CHANNEL  = 3'd3;
    localparam logic [2:0] CFG_EDGE_TYPE     = 3'd4;
    localparam logic [2:0] CFG_POST_CYCLES   = 3'd5;
    localparam logic [2:0] CFG_PRETRIG_EN    = 3'd6;
    localparam int         CFG_IDX_W         = 3;
    localparam int         CFG_DATA_W        = 32;

    // result slots of one queue entry, emitted in this order
    localparam int NUM_SLOTS    = 5;
    localparam int SLOT_STARTED = 0;
    localparam int SLOT_FLUSH   = 1;
    localparam int SLOT_FIRED   = 2;
    localparam int SLOT_RECORD  = 3;
    localparam int SLOT_STOP    = 4;

    // queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;

    // one classified request, expanded later into its results
    typedef struct packed {
        logic [NUM_SLOTS-1:0] slots;
        kind_t                rec_kind;
        logic [31:0]          delta;
        logic [63:0]          ev_time;
        logic [63:0]          rec_base;
        stop_t                stop_reason;
        logic [31:0]          cnt_pre;
        logic [31:0]          cnt_post;
    } latc_entry_t;

endpackage

>>> hw/rtl/logic_analyzer_trigger_capture.sv
// logic analyzer trigger and capture controller, top level. The block takes
// one request (start, sample or host stop) per clock while s_ready is high;
// the front end updates the run state in that same cycle and queues the
// request's results in a four-entry queue, and s_ready drops only while the
// queue is full. A request yields zero to three results, and the back end
// sends one result per clock from its output register while m_ready is
// high, so a request holds the result port until its results are all sent;
// a steady stream with at most one result per request runs at one request
// per clock while m_ready is high. Configuration writes take effect on the
// next clock and are meant for idle periods. No clearing pass follows reset.
`include "logic_analyzer_trigger_capture_defines.svh"
module logic_analyzer_trigger_capture
    import latc_pkg::*;
#(
    parameter int CHANNELS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_func,
    input  logic [CHANNELS-1:0]   s_sample,
    input  logic [63:0]           s_timestamp,
    input  logic                  s_buffer_full,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [2:0]            m_kind,
    output logic [CHANNELS-1:0]   m_sample_out,
    output logic [31:0]           m_delta,
    output logic [63:0]           m_base_time,
    output logic [1:0]            m_stop_reason,
    output logic [31:0]           m_record_count,
    output logic                  m_last
);

    logic                q_push;
    latc_entry_t         q_push_entry;
    logic [CHANNELS-1:0] q_push_sample;
    logic                q_pop;
    latc_entry_t         q_head_entry;
    logic [CHANNELS-1:0] q_head_sample;
    logic                q_empty;
    logic                q_full;
    logic                in_accept;

    assign s_ready   = !q_full;
    assign in_accept = s_valid && s_ready;

    // request classification and run state
    latc_front #(
        .CHANNELS (CHANNELS)
    ) u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wr_data    (cfg_wr_data),
        .in_accept      (in_accept),
        .in_func        (s_func),
        .in_sample      (s_sample),
        .in_timestamp   (s_timestamp),
        .in_buffer_full (s_buffer_full),
        .push           (q_push),
        .push_entry     (q_push_entry),
        .push_sample    (q_push_sample)
    );

    // queue between front and back
    latc_queue #(
        .CHANNELS (CHANNELS)
    ) u_queue (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .push        (q_push),
        .push_entry  (q_push_entry),
        .push_sample (q_push_sample),
        .pop         (q_pop),
        .head_entry  (q_head_entry),
        .head_sample (q_head_sample),
        .empty       (q_empty),
        .full        (q_full)
    );

    // result expansion and output register
    latc_back #(
        .CHANNELS (CHANNELS)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .head_entry     (q_head_entry),
        .head_sample    (q_head_sample),
        .empty          (q_empty),
        .pop            (q_pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_kind         (m_kind),
        .m_sample_out   (m_sample_out),
        .m_delta        (m_delta),
        .m_base_time    (m_base_time),
        .m_stop_reason  (m_stop_reason),
        .m_record_count (m_record_count),
        .m_last         (m_last)
    );

    // checks
    `LATC_ASSERT(a_no_push_when_full, !(q_push && q_full), "push into a full queue")
    `LATC_ASSERT(a_no_pop_when_empty, !(q_pop && q_empty), "pop from an empty queue")
    `LATC_ASSERT(a_push_has_results, q_push |-> (q_push_entry.slots != '0), "empty entry queued")
    `LATC_ASSERT_RST(a_reset_clears_out, !aresetn |=> !m_valid, "result valid after reset")

endmodule

>>> hw/rtl/latc_front.sv
// front end: configuration, run state, trigger test and request classification
module latc_front
    import latc_pkg::*;
#(
    parameter int CHANNELS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                  in_accept,
    input  logic [1:0]            in_func,
    input  logic [CHANNELS-1:0]   in_sample,
    input  logic [63:0]           in_timestamp,
    input  logic                  in_buffer_full,
    output logic                  push,
    output latc_entry_t           push_entry,
    output logic [CHANNELS-1:0]   push_sample
);

    localparam int ECW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    localparam logic [1:0] EDGE_RISE = 2'd1;
    localparam logic [1:0] EDGE_FALL = 2'd2;
    localparam logic [1:0] EDGE_BOTH = 2'd3;

    typedef enum logic [2:0] {
        RUN_IDLE    = 3'b001,
        RUN_ARMED   = 3'b010,
        RUN_CAPTURE = 3'b100
    } run_state_t;

    // configuration registers
    logic                trig_mode_reg;
    logic [CHANNELS-1:0] pat_mask_reg;
    logic [CHANNELS-1:0] pat_value_reg;
    logic [7:0]          edge_ch_reg;
    logic [1:0]          edge_type_reg;
    logic [31:0]         post_cycles_reg;
    logic                pretrig_en_reg;

    // run state
    run_state_t          state_reg, state_next;
    logic [CHANNELS-1:0] prev_sample_reg, prev_sample_next;
    logic [63:0]         prev_time_reg, prev_time_next;
    logic [63:0]         fire_time_reg, fire_time_next;
    logic                fire_valid_reg, fire_valid_next;
    logic                pretrig_reg, pretrig_next;
    logic [31:0]         count_reg, count_next;

    logic [32:0]         delta_diff;
    logic [31:0]         delta;
    logic [31:0]         now_hi_m1;
    logic [63:0]         base_first;
    logic [63:0]         elapsed;
    logic                post_done;
    logic                changed;
    logic                edge_ok;
    logic [ECW-1:0]      edge_idx;
    logic                rise;
    logic                fall;
    logic                hit;
    latc_entry_t         ent;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            trig_mode_reg   <= 1'b0;
            pat_mask_reg    <= '0;
            pat_value_reg   <= '0;
            edge_ch_reg     <= 8'hFF;
            edge_type_reg   <= 2'd0;
            post_cycles_reg <= '0;
            pretrig_en_reg  <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_TRIGGER_MODE:  trig_mode_reg   <= cfg_wr_data[0];
                CFG_PATTERN_MASK:  pat_mask_reg    <= cfg_wr_data[CHANNELS-1:0];
                CFG_PATTERN_VALUE: pat_value_reg   <= cfg_wr_data[CHANNELS-1:0];
                CFG_EDGE_CHANNEL:  edge_ch_reg     <= cfg_wr_data[7:0];
                CFG_EDGE_TYPE:     edge_type_reg   <= cfg_wr_data[1:0];
                CFG_POST_CYCLES:   post_cycles_reg <= cfg_wr_data[31:0];
                CFG_PRETRIG_EN:    pretrig_en_reg  <= cfg_wr_data[0];
                default: ;
            endcase
        end
    end

    // delta since last change and time base of a first record
    assign delta_diff = {1'b0, in_timestamp[31:0]} - {1'b0, prev_time_reg[31:0]};
    assign delta      = delta_diff[31:0];
    assign now_hi_m1  = in_timestamp[63:32] - 32'd1;
    assign base_first = {(delta_diff[32] ? now_hi_m1 : in_timestamp[63:32]),
                         prev_time_reg[31:0]};

    // post-trigger limit
    assign elapsed   = in_timestamp - fire_time_reg;
    assign post_done = (post_cycles_reg != 32'd0) && fire_valid_reg
                       && (state_reg == RUN_CAPTURE)
                       && ((|elapsed[63:32]) || (elapsed[31:0] >= post_cycles_reg));

    // trigger test
    assign changed  = (in_sample != prev_sample_reg);
    assign edge_ok  = (32'(edge_ch_reg) < CHANNELS);
    assign edge_idx = edge_ch_reg[ECW-1:0];
    assign rise     = edge_ok && !prev_sample_reg[edge_idx] && in_sample[edge_idx];
    assign fall     = edge_ok && prev_sample_reg[edge_idx] && !in_sample[edge_idx];
    assign hit      = !trig_mode_reg
                      || ((in_sample & pat_mask_reg) == (pat_value_reg & pat_mask_reg))
                      || ((edge_type_reg == EDGE_RISE) && rise)
                      || ((edge_type_reg == EDGE_FALL) && fall)
                      || ((edge_type_reg == EDGE_BOTH) && (rise || fall));

    // classify the request and compute the next run state
    always_comb begin
        state_next       = state_reg;
        prev_sample_next = prev_sample_reg;
        prev_time_next   = prev_time_reg;
        fire_time_next   = fire_time_reg;
        fire_valid_next  = fire_valid_reg;
        pretrig_next     = pretrig_reg;
        count_next       = count_reg;
        ent              = '0;
        ent.rec_kind     = KIND_RECORD;
        ent.stop_reason  = STOP_POST_DONE;
        ent.delta        = delta;
        ent.ev_time      = in_timestamp;
        ent.cnt_pre      = count_reg;
        if (in_accept) begin
            case (in_func)
                FUNC_START: begin
                    if (state_reg == RUN_IDLE) begin
                        count_next       = '0;
                        prev_sample_next = in_sample;
                        prev_time_next   = in_timestamp;
                        if (!trig_mode_reg) begin
                            fire_time_next  = in_timestamp;
                            fire_valid_next = 1'b1;
                            state_next      = RUN_CAPTURE;
                        end else begin
                            fire_time_next  = '0;
                            fire_valid_next = 1'b0;
                            state_next      = RUN_ARMED;
                            pretrig_next    = pretrig_en_reg;
                        end
                        ent.slots[SLOT_STARTED] = 1'b1;
                    end
                end
                FUNC_STOP: begin
                    if (state_reg != RUN_IDLE) begin
                        state_next            = RUN_IDLE;
                        ent.slots[SLOT_STOP]  = 1'b1;
                        ent.stop_reason       = STOP_HOST;
                    end
                end
                FUNC_SAMPLE: begin
                    if ((state_reg != RUN_IDLE) && changed) begin
                        if ((state_reg == RUN_ARMED) && !hit) begin
                            // pre-trigger transition
                            if (pretrig_reg) begin
                                ent.slots[SLOT_RECORD] = 1'b1;
                                ent.rec_kind           = KIND_PRE_REC;
                            end
                            prev_sample_next = in_sample;
                            prev_time_next   = in_timestamp;
                        end else begin
                            // trigger fires on this transition if armed; else a capture transition
                            if (state_reg == RUN_ARMED) begin
                                fire_time_next  = in_timestamp;
                                fire_valid_next = 1'b1;
                                if (pretrig_reg) begin
                                    ent.slots[SLOT_FLUSH] = 1'b1;
                                    pretrig_next          = 1'b0;
                                end
                                state_next             = RUN_CAPTURE;
                                ent.slots[SLOT_FIRED]  = 1'b1;
                            end
                            if (post_done) begin
                                if (!in_buffer_full) begin
                                    ent.rec_base = (count_reg == 32'd0) ? prev_time_reg : '0;
                                    count_next   = count_reg + 32'd1;
                                    ent.slots[SLOT_RECORD] = 1'b1;
                                end
                                prev_sample_next     = in_sample;
                                prev_time_next       = in_timestamp;
                                state_next           = RUN_IDLE;
                                ent.slots[SLOT_STOP] = 1'b1;
                                ent.stop_reason      = STOP_POST_DONE;
                            end else if (in_buffer_full) begin
                                state_next           = RUN_IDLE;
                                ent.slots[SLOT_STOP] = 1'b1;
                                ent.stop_reason      = STOP_OVERFLOW;
                            end else begin
                                ent.rec_base = (count_reg == 32'd0) ? base_first : '0;
                                count_next   = count_reg + 32'd1;
                                ent.slots[SLOT_RECORD] = 1'b1;
                                prev_sample_next = in_sample;
                                prev_time_next   = in_timestamp;
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
        ent.cnt_post = count_next;
    end

    // run state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= RUN_IDLE;
            prev_sample_reg <= '0;
            prev_time_reg   <= '0;
            fire_time_reg   <= '0;
            fire_valid_reg  <= 1'b0;
            pretrig_reg     <= 1'b0;
            count_reg       <= '0;
        end else begin
            state_reg       <= state_next;
            prev_sample_reg <= prev_sample_next;
            prev_time_reg   <= prev_time_next;
            fire_time_reg   <= fire_time_next;
            fire_valid_reg  <= fire_valid_next;
            pretrig_reg     <= pretrig_next;
            count_reg       <= count_next;
        end
    end

    assign push        = in_accept && (ent.slots != '0);
    assign push_entry  = ent;
    assign push_sample = in_sample;

endmodule

>>> hw/rtl/latc_queue.sv
// short queue of classified requests between front and back
module latc_queue
    import latc_pkg::*;
#(
    parameter int CHANNELS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  latc_entry_t         push_entry,
    input  logic [CHANNELS-1:0] push_sample,
    input  logic                pop,
    output latc_entry_t         head_entry,
    output logic [CHANNELS-1:0] head_sample,
    output logic                empty,
    output logic                full
);

    latc_entry_t         entry_mem [Q_DEPTH];
    logic [CHANNELS-1:0] sample_mem [Q_DEPTH];
    logic [Q_AW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [Q_AW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [Q_AW:0]       count_reg, count_next;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == (Q_AW+1)'(Q_DEPTH));

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_mem[wr_ptr_reg]  <= push_entry;
            sample_mem[wr_ptr_reg] <= push_sample;
        end
    end

    assign head_entry  = entry_mem[rd_ptr_reg];
    assign head_sample = sample_mem[rd_ptr_reg];

endmodule

>>> hw/rtl/latc_back.sv
// back end: expands queued requests into results through an output register
module latc_back
    import latc_pkg::*;
#(
    parameter int CHANNELS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  latc_entry_t         head_entry,
    input  logic [CHANNELS-1:0] head_sample,
    input  logic                empty,
    output logic                pop,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [2:0]          m_kind,
    output logic [CHANNELS-1:0] m_sample_out,
    output logic [31:0]         m_delta,
    output logic [63:0]         m_base_time,
    output logic [1:0]          m_stop_reason,
    output logic [31:0]         m_record_count,
    output logic                m_last
);

    logic [NUM_SLOTS-1:0] done_reg, done_next;
    logic [NUM_SLOTS-1:0] remain;
    logic [NUM_SLOTS-1:0] sel;
    logic                 sel_last;
    logic                 load;

    logic                 valid_reg, valid_next;
    kind_t                kind_reg, kind_next;
    logic [CHANNELS-1:0]  sample_reg, sample_next;
    logic [31:0]          delta_reg, delta_next;
    logic [63:0]          base_reg, base_next;
    stop_t                reason_reg, reason_next;
    logic [31:0]          count_reg, count_next;
    logic                 last_reg, last_next;

    // pick the next pending slot of the head entry
    assign remain   = head_entry.slots & ~done_reg;
    assign sel      = remain & (~remain + 1'b1);
    assign sel_last = ((remain & ~sel) == '0);
    assign load     = !empty && (!valid_reg || m_ready);
    assign pop      = load && sel_last;

    always_comb begin
        done_next = done_reg;
        if (load) begin
            done_next = sel_last ? '0 : (done_reg | sel);
        end
    end

    // result fields for the selected slot
    always_comb begin
        valid_next  = valid_reg && !m_ready;
        kind_next   = kind_reg;
        sample_next = sample_reg;
        delta_next  = delta_reg;
        base_next   = base_reg;
        reason_next = reason_reg;
        count_next  = count_reg;
        last_next   = last_reg;
        if (load) begin
            valid_next  = 1'b1;
            last_next   = sel_last;
            sample_next = '0;
            delta_next  = '0;
            base_next   = '0;
            reason_next = STOP_POST_DONE;
            count_next  = head_entry.cnt_post;
            if (sel[SLOT_STARTED]) begin
                kind_next = KIND_STARTED;
                base_next = head_entry.ev_time;
            end else if (sel[SLOT_FLUSH]) begin
                kind_next  = KIND_FLUSH;
                count_next = head_entry.cnt_pre;
            end else if (sel[SLOT_FIRED]) begin
                kind_next  = KIND_FIRED;
                base_next  = head_entry.ev_time;
                count_next = head_entry.cnt_pre;
            end else if (sel[SLOT_RECORD]) begin
                kind_next   = head_entry.rec_kind;
                sample_next = head_sample;
                delta_next  = head_entry.delta;
                base_next   = head_entry.rec_base;
            end else begin
                kind_next   = KIND_STOPPED;
                reason_next = head_entry.stop_reason;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_reg  <= '0;
            valid_reg <= 1'b0;
        end else begin
            done_reg  <= done_next;
            valid_reg <= valid_next;
        end
    end

    // output payload register
    always_ff @(posedge aclk) begin
        kind_reg   <= kind_next;
        sample_reg <= sample_next;
        delta_reg  <= delta_next;
        base_reg   <= base_next;
        reason_reg <= reason_next;
        count_reg  <= count_next;
        last_reg   <= last_next;
    end

    assign m_valid        = valid_reg;
    assign m_kind         = kind_reg;
    assign m_sample_out   = sample_reg;
    assign m_delta        = delta_reg;
    assign m_base_time    = base_reg;
    assign m_stop_reason  = reason_reg;
    assign m_record_count = count_reg;
    assign m_last         = last_reg;

endmodule
